/* src/spc_pkg.sv */
// Shared widths, register indexes, CORDIC table and stage payload type.
package spc_pkg;

  localparam int unsigned MaxBeams   = 4096;
  localparam int unsigned CordSteps  = 18;
  localparam int unsigned RangeW     = 16;
  localparam int unsigned IndexW     = 12;
  localparam int unsigned AngleW     = 16;
  localparam int unsigned CoordW     = 17;
  localparam int unsigned VecW       = 33;   // Q14 vector, headroom for CORDIC gain
  localparam int unsigned ZW         = 25;   // residual angle, 2^-24 turn
  localparam int unsigned AtanW      = 22;
  localparam int unsigned ShiftW     = 5;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned GainW      = 30;
  localparam logic [GainW-1:0] InvGainQ30 = 30'd652032874;
  localparam logic signed [CoordW-1:0] CoordMax = 17'sd65535;

  localparam logic [CfgIdxW-1:0] RegStartAngle = 8'd0;
  localparam logic [CfgIdxW-1:0] RegAngleStep  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegMinRange   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegMaxRange   = 8'd3;

  // Payload handed from cell to cell.
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
    logic [1:0]             quad;
    logic [IndexW-1:0]      idx;
  } cord_t;

  // round(atan(2^-i) / (2 pi) * 2^24)
  function automatic logic [AtanW-1:0] atan_val(input int unsigned i);
    logic [AtanW-1:0] v;
    v = '0;
    unique case (i)
      0:  v = 22'd2097152;
      1:  v = 22'd1238021;
      2:  v = 22'd654136;
      3:  v = 22'd332050;
      4:  v = 22'd166669;
      5:  v = 22'd83416;
      6:  v = 22'd41718;
      7:  v = 22'd20860;
      8:  v = 22'd10430;
      9:  v = 22'd5215;
      10: v = 22'd2608;
      11: v = 22'd1304;
      12: v = 22'd652;
      13: v = 22'd326;
      14: v = 22'd163;
      15: v = 22'd81;
      16: v = 22'd41;
      17: v = 22'd20;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/spc_prep.sv */
// Config registers, sample filter, beam angle and CORDIC start vector.
module spc_prep import spc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [AngleW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RangeW-1:0]   range_i,
  input  logic                invalid_i,
  input  logic [IndexW-1:0]   index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cord_t               out_o
);

  logic [AngleW-1:0] start_q, step_q;
  logic [RangeW-1:0] min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      step_q  <= '0;
      min_q   <= '0;
      max_q   <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegStartAngle) start_q <= cfg_data_i;
      if (cfg_index_i == RegAngleStep)  step_q  <= cfg_data_i;
      if (cfg_index_i == RegMinRange)   min_q   <= cfg_data_i;
      if (cfg_index_i == RegMaxRange)   max_q   <= cfg_data_i;
    end
  end

  // Stage A: filter, beam angle.
  logic                a_vld_q;
  logic [RangeW-1:0]   a_range_q;
  logic [IndexW-1:0]   a_idx_q;
  logic [AngleW-1:0]   a_ang_q;
  logic                a_rdy;
  logic                keep;
  logic [IndexW+AngleW-1:0] prod;
  logic                b_vld_q;
  logic                b_rdy;

  assign keep = !invalid_i && (range_i >= min_q) && (range_i <= max_q)
              && ({5'b0, index_i} < 17'(MaxBeams));
  assign prod = index_i * step_q;
  assign a_rdy = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (a_rdy) a_vld_q <= in_valid_i && keep;
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_range_q <= range_i;
      a_idx_q   <= index_i;
      a_ang_q   <= start_q + prod[AngleW-1:0];
    end
  end

  // Stage B: quadrant split and start vector.
  logic [AngleW-1:0]        biased;
  logic [1:0]               quad;
  logic [AngleW-1:0]        resid;
  logic [RangeW+GainW-1:0]  xprod;
  cord_t                    b_q;

  assign biased = a_ang_q + 16'd8192;
  assign quad   = biased[15:14];
  assign resid  = a_ang_q - {quad, 14'b0};
  assign xprod  = a_range_q * InvGainQ30;
  assign b_rdy  = !b_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (b_rdy) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_vld_q) begin
      b_q.x    <= signed'({3'b0, xprod[RangeW+GainW-1:RangeW]});
      b_q.y    <= '0;
      b_q.z    <= signed'({resid[AngleW-1], resid, 8'b0});
      b_q.quad <= quad;
      b_q.idx  <= a_idx_q;
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_o       = b_q;

endmodule

/* src/spc_cell.sv */
// One CORDIC rotation step with its own pipeline register.
module spc_cell import spc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ShiftW-1:0] shift_i,
  input  logic [AtanW-1:0]  atan_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cord_t             in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cord_t             out_o
);

  logic                   vld_q;
  cord_t                  data_q, data_d;
  logic signed [VecW-1:0] dx, dy;
  logic signed [ZW-1:0]   da;
  logic                   rdy;

  assign dx  = in_i.y >>> shift_i;
  assign dy  = in_i.x >>> shift_i;
  assign da  = signed'({3'b0, atan_i});
  assign rdy = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    data_d = in_i;
    if (!in_i.z[ZW-1]) begin
      data_d.x = in_i.x - dx;
      data_d.y = in_i.y + dy;
      data_d.z = in_i.z - da;
    end else begin
      data_d.x = in_i.x + dx;
      data_d.y = in_i.y - dy;
      data_d.z = in_i.z + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (rdy) vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) data_q <= data_d;
  end

  assign out_valid_o = vld_q;
  assign out_o       = data_q;

endmodule

/* src/spc_post.sv */
// Quadrant restore, rounding, saturation and output register.
module spc_post import spc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  cord_t                    in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] x_o,
  output logic signed [CoordW-1:0] y_o,
  output logic [IndexW-1:0]        idx_o
);

  function automatic logic signed [CoordW-1:0] round_sat(input logic signed [VecW:0] v);
    logic signed [VecW:0]     s;
    logic signed [VecW-14:0]  r;
    logic signed [CoordW-1:0] o;
    s = v + 34'sd8192;
    r = s[VecW:14];
    if (r > 20'sd65535)       o = CoordMax;
    else if (r < -20'sd65535) o = -CoordMax;
    else                      o = r[CoordW-1:0];
    return o;
  endfunction

  logic signed [VecW:0]     fx, fy;
  logic                     vld_q, rdy;
  logic signed [CoordW-1:0] x_q, y_q;
  logic [IndexW-1:0]        idx_q;

  always_comb begin
    unique case (in_i.quad)
      2'd1: begin
        fx = -{in_i.y[VecW-1], in_i.y};
        fy = {in_i.x[VecW-1], in_i.x};
      end
      2'd2: begin
        fx = -{in_i.x[VecW-1], in_i.x};
        fy = -{in_i.y[VecW-1], in_i.y};
      end
      2'd3: begin
        fx = {in_i.y[VecW-1], in_i.y};
        fy = -{in_i.x[VecW-1], in_i.x};
      end
      default: begin
        fx = {in_i.x[VecW-1], in_i.x};
        fy = {in_i.y[VecW-1], in_i.y};
      end
    endcase
  end

  assign rdy = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (rdy) vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      x_q   <= round_sat(fx);
      y_q   <= round_sat(fy);
      idx_q <= in_i.idx;
    end
  end

  assign out_valid_o = vld_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign idx_o       = idx_q;

endmodule

/* src/scan_polar_to_cartesian.sv */
// Top level: laser scan sample to Cartesian point converter.
//
//   channel   direction  payload
//   s_axis    in         tdata: range_mm, beam_index; tuser: is_invalid
//   m_axis    out        tdata: point_x, point_y, point_index
//   cfg       in         cfg_index_i selects register, cfg_data_i value
//
// One sample per cycle sustained while the output is not stalled; a kept
// sample passes two prep stages, 18 CORDIC cells and one output stage.
// Dropped samples leave a bubble and produce nothing.
// Each stage holds when the one after it is full and stalled, so ready
// ripples back through the row; empty stages keep taking samples.
// Reset clears all valid bits and restores the register defaults.
module scan_polar_to_cartesian import spc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // range_mm[15:0], beam_index[27:16], zero
  input  logic [0:0]          s_axis_tuser,   // is_invalid[0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // point_x[16:0], point_y[33:17],
                                              // point_index[45:34], zero
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [AngleW-1:0]   cfg_data_i
);

  // Registers are written directly on cfg_valid_i, never back-pressured.
  assign cfg_ready_o = 1'b1;

  logic  vld [CordSteps+1];
  logic  rdy [CordSteps+1];
  cord_t dat [CordSteps+1];

  spc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .range_i     (s_axis_tdata[15:0]),
    .invalid_i   (s_axis_tuser[0]),
    .index_i     (s_axis_tdata[27:16]),
    .out_valid_o (vld[0]),
    .out_ready_i (rdy[0]),
    .out_o       (dat[0])
  );

  // Row of rotation cells; shift and table angle are fixed per position.
  for (genvar g = 0; g < CordSteps; g++) begin : g_cell
    spc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (ShiftW'(g)),
      .atan_i      (atan_val(g)),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .in_i        (dat[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .out_o       (dat[g+1])
    );
  end

  logic signed [CoordW-1:0] px, py;
  logic [IndexW-1:0]        pidx;

  spc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[CordSteps]),
    .in_ready_o  (rdy[CordSteps]),
    .in_i        (dat[CordSteps]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .x_o         (px),
    .y_o         (py),
    .idx_o       (pidx)
  );

  assign m_axis_tdata = {2'b0, pidx, py, px};

`ifndef NO_ASSERTIONS
  // An empty output stage means every stage upstream can move.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");

  // Saturation keeps coordinates off the most negative code.
  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] != 17'h10000)) else $error("point_x not clamped");

  a_y_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33:17] != 17'h10000)) else $error("point_y not clamped");

  // A stalled result must not be overwritten by the pipeline behind it.
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result lost");
`endif

endmodule

/* tb/tb_scan_polar_to_cartesian.sv */
// Testbench for the laser scan polar-to-Cartesian converter: stream stimulus, CORDIC predictor.
module tb_scan_polar_to_cartesian;
  import spc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Dropped samples give no result, so after the last point comes out the
  // pipe may still hold bubbles: wait out the pipeline depth with margin.
  localparam int SettleCycles = 40;
  localparam int FifoDepth = 1024;
  localparam logic [CfgIdxW-1:0] RegSpareFirst = RegMaxRange + 1'b1;

  // One range sample as it travels on the input stream.
  typedef struct packed {
    logic [RangeW-1:0] range_mm;
    logic              is_invalid;
    logic [IndexW-1:0] beam_index;
  } sample_t;

  // One Cartesian point as it leaves the block.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [IndexW-1:0]        idx;
  } point_t;

  // atan(2^-i) in 2^-24 turn, one entry per micro-rotation
  localparam longint MicroRot [CordSteps] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [AngleW-1:0]   cfg_data_i = '0;

  // Shadow copy of the configuration registers (reset values).
  logic [AngleW-1:0] fov_start   = '0;
  logic [AngleW-1:0] fov_step    = '0;
  logic [RangeW-1:0] range_floor = '0;
  logic [RangeW-1:0] range_ceil  = '1;

  // Ring buffers: samples waiting for the driver, points predicted but not yet seen.
  sample_t scan_buf [FifoDepth];
  int      scan_wr = 0;
  int      scan_rd = 0;
  point_t  point_buf [FifoDepth];
  int      point_wr = 0;
  int      point_rd = 0;
  sample_t next_sample;
  point_t  want;
  logic signed [CoordW-1:0] got_x, got_y;
  logic [IndexW-1:0] got_idx;

  bit sample_taken = 1'b0;    // input transfer at the last rising edge
  int idle_pct = 0;           // chance per cycle that an idle burst starts
  int src_gap = 0;
  int sink_gap = 0;
  int fail_count = 0;

  always #4 clk_i = ~clk_i;

  scan_polar_to_cartesian uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Range gate: NaN and out-of-window samples vanish; both bounds are kept.
  function automatic bit sample_kept(logic [RangeW-1:0] rng, logic inv);
    return !inv && rng >= range_floor && rng <= range_ceil;
  endfunction

  // Q14 to millimetres, round half up, saturate at +-65535.
  function automatic logic signed [CoordW-1:0] round_coord(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65535) r = 65535;
    if (r < -65535) r = -65535;
    return CoordW'(r);
  endfunction

  // Beam angle from the scan geometry, quadrant split off exactly, then an
  // 18-step rotation of (r/K, 0) through the residual angle.
  function automatic point_t beam_to_point(logic [RangeW-1:0] rng, logic [IndexW-1:0] idx);
    logic [AngleW-1:0] ang;
    logic [AngleW-1:0] resid;
    logic [1:0]        quad;
    longint x, y, z, dx, dy, fx, fy, rl;
    point_t p;
    ang   = fov_start + AngleW'(idx) * fov_step;
    quad  = 2'((ang + 16'd8192) >> 14);
    resid = ang - {quad, 14'd0};
    z     = longint'($signed(resid)) * 256;
    rl    = longint'(rng);
    x     = (rl * longint'(InvGainQ30)) >>> 16;
    y     = 0;
    for (int i = 0; i < CordSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - MicroRot[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + MicroRot[i];
      end
    end
    case (quad)
      2'd1: begin fx = -y; fy = x;  end
      2'd2: begin fx = -x; fy = -y; end
      2'd3: begin fx = y;  fy = -x; end
      default: begin fx = x; fy = y; end
    endcase
    p.x   = round_coord(fx);
    p.y   = round_coord(fy);
    p.idx = idx;
    return p;
  endfunction

  // Sample driver: holds an item until its transfer, idles in short bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || sample_taken) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (scan_wr != scan_rd && $urandom_range(0, 99) < idle_pct) begin
          src_gap = $urandom_range(0, 4);
          s_axis_tvalid <= 1'b0;
        end else if (scan_wr != scan_rd) begin
          next_sample = scan_buf[scan_rd % FifoDepth];
          scan_rd++;
          s_axis_tdata  <= {4'd0, next_sample.beam_index, next_sample.range_mm};
          s_axis_tuser  <= next_sample.is_invalid;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Point sink: applies back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        sink_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  // against the oldest pending point.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      sample_taken = s_axis_tvalid && s_axis_tready;
      if (sample_taken && sample_kept(s_axis_tdata[15:0], s_axis_tuser[0])) begin
        point_buf[point_wr % FifoDepth] = beam_to_point(s_axis_tdata[15:0],
                                                        s_axis_tdata[27:16]);
        point_wr++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_x   = m_axis_tdata[16:0];
        got_y   = m_axis_tdata[33:17];
        got_idx = m_axis_tdata[45:34];
        if (point_wr == point_rd) begin
          $error("unexpected point: x %0d y %0d index %0d", got_x, got_y, got_idx);
          fail_count++;
        end else begin
          want = point_buf[point_rd % FifoDepth];
          point_rd++;
          if (got_x !== want.x) begin
            $error("point_x mismatch: expected %0d, got %0d", want.x, got_x);
            fail_count++;
          end
          if (got_y !== want.y) begin
            $error("point_y mismatch: expected %0d, got %0d", want.y, got_y);
            fail_count++;
          end
          if (got_idx !== want.idx) begin
            $error("point_index mismatch: expected %0d, got %0d", want.idx, got_idx);
            fail_count++;
          end
        end
      end
    end
  end

  // Register write over the config channel; shadow follows on the transfer.
  task automatic write_reg(input logic [CfgIdxW-1:0] ridx, input logic [AngleW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ridx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (ridx)
      RegStartAngle: fov_start   = val;
      RegAngleStep:  fov_step    = val;
      RegMinRange:   range_floor = val;
      RegMaxRange:   range_ceil  = val;
      default: ; // spare index, no effect
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_sample(input logic [RangeW-1:0] rng, input logic inv,
                            input logic [IndexW-1:0] idx);
    scan_buf[scan_wr % FifoDepth] = '{range_mm: rng, is_invalid: inv, beam_index: idx};
    scan_wr++;
  endtask

  // Sender holds off until the queue is sent and every point is back,
  // then lets the pipe empty of bubbles.
  task automatic drain();
    do @(posedge clk_i);
    while (scan_wr != scan_rd || s_axis_tvalid || point_wr != point_rd);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One random scan: fresh geometry and range window, then mostly sweeps
  // of consecutive beams inside the window, with noise mixed in.
  task automatic scan_phase(input int n_items, input int idle);
    int lo, hi;
    logic [AngleW-1:0] st, sp;
    logic [IndexW-1:0] idx;
    st = AngleW'($urandom);
    case ($urandom_range(0, 3))
      0: sp = AngleW'($urandom);
      1: sp = AngleW'($urandom_range(0, 16) - 8);
      2: sp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: sp = AngleW'($urandom_range(1, 40));
    endcase
    lo = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4000);
    hi = $urandom_range(0, 1) ? 65535 : $urandom_range(lo, 65535);
    write_reg(RegStartAngle, st);
    write_reg(RegAngleStep, sp);
    write_reg(RegMinRange, RangeW'(lo));
    write_reg(RegMaxRange, RangeW'(hi));
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIdxW'($urandom_range(RegSpareFirst, 255)), AngleW'($urandom));
    idle_pct = idle;
    idx = IndexW'($urandom);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 4) != 0) begin
        idx = idx + 1'b1;
        add_sample(RangeW'($urandom_range(lo, hi)), $urandom_range(0, 19) == 0, idx);
      end else begin
        add_sample(RangeW'($urandom), $urandom_range(0, 2) == 0, IndexW'($urandom));
      end
    end
    drain();
  endtask

  // Run limit, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_pct = 20;

    // Reset geometry: every beam at angle zero; full range hits saturation.
    add_sample(16'd0, 1'b0, 12'd0);
    add_sample(16'hFFFF, 1'b0, 12'hFFF);
    add_sample(16'hFFFF, 1'b1, 12'd0);
    add_sample(16'd1, 1'b0, 12'd2048);
    drain();

    // Window edges and the first quadrant boundary (8191 -> 8192).
    write_reg(RegStartAngle, 16'd8191);
    write_reg(RegAngleStep, 16'd1);
    write_reg(RegMinRange, 16'd100);
    write_reg(RegMaxRange, 16'd60000);
    write_reg(CfgIdxW'($urandom_range(RegSpareFirst, 255)), 16'hFFFF);
    add_sample(16'd99, 1'b0, 12'd0);
    add_sample(16'd100, 1'b0, 12'd0);
    add_sample(16'd60000, 1'b0, 12'd1);
    add_sample(16'd60001, 1'b0, 12'd1);
    add_sample(16'd30000, 1'b0, 12'hFFF);
    add_sample(16'd30000, 1'b1, 12'd2);
    drain();

    // Extreme geometry, window pinned to the top range value.
    write_reg(RegStartAngle, 16'h8000);
    write_reg(RegAngleStep, 16'h7FFF);
    write_reg(RegMinRange, 16'hFFFF);
    write_reg(RegMaxRange, 16'hFFFF);
    add_sample(16'hFFFF, 1'b0, 12'd0);
    add_sample(16'hFFFF, 1'b0, 12'd1);
    add_sample(16'hFFFF, 1'b0, 12'd3);
    add_sample(16'hFFFE, 1'b0, 12'd2);
    drain();

    // Exact quarter turns; half-turn step.
    write_reg(RegStartAngle, 16'd16384);
    write_reg(RegAngleStep, 16'h8000);
    write_reg(RegMinRange, 16'd0);
    write_reg(RegMaxRange, 16'hFFFF);
    add_sample(16'd45000, 1'b0, 12'd0);
    add_sample(16'd45000, 1'b0, 12'd1);
    add_sample(16'd0, 1'b0, 12'hFFF);
    add_sample(16'hFFFF, 1'b0, 12'd2);
    drain();

    // Crossed bounds: nothing may come out.
    write_reg(RegMinRange, 16'd5000);
    write_reg(RegMaxRange, 16'd4999);
    add_sample(16'd4999, 1'b0, 12'd5);
    add_sample(16'd5000, 1'b0, 12'd6);
    add_sample(16'd0, 1'b0, 12'd0);
    add_sample(16'hFFFF, 1'b0, 12'hFFF);
    drain();

    // Random scans; idle-free stretches between, and one at the end.
    scan_phase(100, 20);
    scan_phase(100, 0);
    scan_phase(100, 30);
    scan_phase(100, 10);
    scan_phase(100, 40);
    scan_phase(100, 15);
    scan_phase(100, 0);

    if (fail_count == 0 && point_wr == point_rd) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
